[hdl/isotp_pkg.sv]
// shared types, constants and helper functions for the iso-tp receive vin extractor
package isotp_pkg;

  localparam int unsigned CAN_ID_W     = 29;
  localparam int unsigned BYTE_CNT_W   = 4;
  localparam int unsigned FRAME_W      = 64;
  localparam int unsigned CHAR_IDX_W   = 5;
  localparam int unsigned MSG_LEN_W    = 12;

  localparam logic [CAN_ID_W-1:0]  RESPONSE_ID_RST = 29'h60F;
  localparam logic [7:0]           NEG_RESP_SID    = 8'h7F;
  localparam logic [7:0]           VIN_HDR_0       = 8'h62;
  localparam logic [7:0]           VIN_HDR_1       = 8'hF1;
  localparam logic [7:0]           VIN_HDR_2       = 8'h90;
  localparam logic [MSG_LEN_W-1:0] VIN_MIN_LEN     = 12'd20;
  localparam logic [3:0]           MAX_BYTES       = 4'd8;
  localparam logic [3:0]           MIN_BYTES       = 4'd2;
  localparam logic [3:0]           SF_MAX_LEN      = 4'd7;
  localparam logic [2:0]           FF_MAX_TAKE     = 3'd6;
  localparam logic [2:0]           FF_FIRST_BYTE   = 3'd2;
  localparam logic [2:0]           CF_FIRST_BYTE   = 3'd1;

  typedef enum logic [3:0] {
    PCI_SINGLE = 4'd0,
    PCI_FIRST  = 4'd1,
    PCI_CONSEC = 4'd2
  } pci_type_t;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_SINGLE   = 3'd1,
    EV_NEGATIVE = 3'd2,
    EV_FIRST    = 3'd3,
    EV_CONSEC   = 3'd4,
    EV_SEQ_ERR  = 3'd5,
    EV_DONE     = 3'd6,
    EV_VIN      = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    KIND_IGN,
    KIND_SF,
    KIND_NEG,
    KIND_FF,
    KIND_CF,
    KIND_SEQ
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_FF_FEED,
    S_FF_DONE,
    S_CF_FEED,
    S_CF_DONE,
    S_VREAD,
    S_VOUT
  } state_t;

  typedef struct packed {
    logic   in_ready;
    logic   ff_init;
    logic   cf_start;
    logic   feed;
    logic   cap_clr;
    logic   load;
    event_t evt;
    logic   emit_clr;
    logic   emit_inc;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  take_zero;
    logic  incomplete;
    logic  vin_ok;
    logic  out_free;
    logic  emit_last;
  } sts_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = VIN_HDR_0;
      2'd1:    b = VIN_HDR_1;
      2'd2:    b = VIN_HDR_2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hdl/isotp_in_if.sv]
// input channel carrying one received can frame
interface isotp_in_if;
  logic        valid;
  logic        ready;
  logic [28:0] can_id;
  logic [3:0]  byte_count;
  logic [63:0] frame_data;

  modport source (output valid, can_id, byte_count, frame_data, input ready);
  modport sink (input valid, can_id, byte_count, frame_data, output ready);
endinterface

[hdl/isotp_out_if.sv]
// output channel carrying one result item
interface isotp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] service_id;
  logic [7:0] reject_code;
  logic [7:0] vin_char;
  logic [4:0] char_index;
  logic       last;

  modport source (output valid, event_res, service_id, reject_code, vin_char, char_index,
                  last, input ready);
  modport sink (input valid, event_res, service_id, reject_code, vin_char, char_index,
                last, output ready);
endinterface

[hdl/isotp_ctrl.sv]
// controller state machine sequencing classification, byte feeding and result output
module isotp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  isotp_pkg::sts_t   sts,
  output isotp_pkg::cmd_t   cmd
);
  import isotp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.evt      = EV_IGNORED;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        case (sts.kind)
          KIND_FF: begin
            cmd.ff_init = 1'b1;
            state_next  = S_FF_FEED;
          end
          KIND_CF: begin
            cmd.cf_start = 1'b1;
            state_next   = S_CF_FEED;
          end
          KIND_SF: begin
            cmd.evt = EV_SINGLE;
            if (sts.out_free) begin
              cmd.load   = 1'b1;
              state_next = S_IDLE;
            end
          end
          KIND_NEG: begin
            cmd.evt = EV_NEGATIVE;
            if (sts.out_free) begin
              cmd.load   = 1'b1;
              state_next = S_IDLE;
            end
          end
          KIND_SEQ: begin
            cmd.evt = EV_SEQ_ERR;
            if (sts.out_free) begin
              cmd.load    = 1'b1;
              cmd.cap_clr = 1'b1;
              state_next  = S_IDLE;
            end
          end
          default: begin
            cmd.evt = EV_IGNORED;
            if (sts.out_free) begin
              cmd.load   = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_FF_FEED: begin
        if (sts.take_zero) begin
          state_next = S_FF_DONE;
        end else begin
          cmd.feed = 1'b1;
        end
      end
      S_FF_DONE: begin
        cmd.evt = EV_FIRST;
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CF_FEED: begin
        if (sts.take_zero) begin
          state_next = S_CF_DONE;
        end else begin
          cmd.feed = 1'b1;
        end
      end
      S_CF_DONE: begin
        if (sts.incomplete) begin
          cmd.evt = EV_CONSEC;
          if (sts.out_free) begin
            cmd.load   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.vin_ok) begin
          cmd.cap_clr  = 1'b1;
          cmd.emit_clr = 1'b1;
          state_next   = S_VREAD;
        end else begin
          cmd.evt = EV_DONE;
          if (sts.out_free) begin
            cmd.load    = 1'b1;
            cmd.cap_clr = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_VREAD: begin
        state_next = S_VOUT;
      end
      S_VOUT: begin
        cmd.evt = EV_VIN;
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.emit_inc = 1'b1;
            state_next   = S_VREAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/isotp_dp.sv]
// datapath: frame register, reassembly state, vin store and output register
module isotp_dp #(
  parameter int unsigned VIN_CHARS = 17
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [isotp_pkg::CAN_ID_W-1:0]       cfg_wr_data,
  isotp_in_if.sink                             in_ch,
  isotp_out_if.source                          out_ch,
  input  isotp_pkg::cmd_t                      cmd,
  output isotp_pkg::sts_t                      sts
);
  import isotp_pkg::*;

  localparam int unsigned IW = (VIN_CHARS > 1) ? $clog2(VIN_CHARS) : 1;
  localparam int unsigned CW = $clog2(VIN_CHARS + 1);

  logic [CAN_ID_W-1:0]  response_id;
  logic                 id_match;
  logic [3:0]           nbytes;
  logic [FRAME_W-1:0]   frame;

  logic                 capture_active;
  logic [MSG_LEN_W-1:0] expected_length;
  logic [3:0]           next_sequence;
  logic [MSG_LEN_W-1:0] received_count;
  logic [1:0]           header_match;
  logic                 header_ok;
  logic [CW-1:0]        vin_count;
  logic [2:0]           byte_idx;
  logic [2:0]           take_cnt;
  logic [IW-1:0]        emit_idx;

  logic [7:0]           vin_mem [VIN_CHARS];
  logic [7:0]           rd_data;

  logic                 out_valid;
  logic [2:0]           event_res;
  logic [7:0]           service_id;
  logic [7:0]           reject_code;
  logic [7:0]           vin_char;
  logic [CHAR_IDX_W-1:0] char_index;
  logic                 last;

  logic                 accept;
  logic [7:0]           pci;
  logic [3:0]           pci_nib;
  logic [7:0]           byte1;
  logic [7:0]           byte2;
  logic [7:0]           byte3;
  logic [7:0]           cur_byte;
  logic [MSG_LEN_W-1:0] ff_len;
  logic [MSG_LEN_W-1:0] remaining;
  logic [2:0]           nm1;
  logic [1:0]           hm_next;
  logic                 collect;
  kind_t                kind;

  assign accept   = in_ch.valid & cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;

  assign pci      = frame[63:56];
  assign pci_nib  = pci[3:0];
  assign byte1    = frame[55:48];
  assign byte2    = frame[47:40];
  assign byte3    = frame[39:32];
  assign cur_byte = frame[{~byte_idx, 3'b000} +: 8];
  assign ff_len   = {pci_nib, byte1};
  assign remaining = expected_length - received_count;
  assign nm1      = 3'(nbytes - 4'd1);

  always_comb begin
    kind = KIND_IGN;
    if (id_match && nbytes >= MIN_BYTES) begin
      case (pci[7:4])
        PCI_SINGLE: begin
          if (pci_nib == 4'd0 || pci_nib > SF_MAX_LEN ||
              {1'b0, nbytes} < ({1'b0, pci_nib} + 5'd1)) begin
            kind = KIND_IGN;
          end else if (pci_nib >= 4'd3 && byte1 == NEG_RESP_SID) begin
            kind = KIND_NEG;
          end else begin
            kind = KIND_SF;
          end
        end
        PCI_FIRST: begin
          kind = (nbytes == MAX_BYTES) ? KIND_FF : KIND_IGN;
        end
        PCI_CONSEC: begin
          if (capture_active) begin
            kind = (pci_nib == next_sequence) ? KIND_CF : KIND_SEQ;
          end
        end
        default: kind = KIND_IGN;
      endcase
    end
  end

  always_comb begin
    hm_next = header_match;
    if (header_match == received_count[1:0] && cur_byte == hdr_byte(received_count[1:0])) begin
      hm_next = header_match + 2'd1;
    end
  end

  assign collect = (received_count >= 12'd3) && (vin_count < CW'(VIN_CHARS)) &&
                   is_alnum(cur_byte);

  always_comb begin
    sts            = '0;
    sts.kind       = kind;
    sts.take_zero  = (take_cnt == 3'd0);
    sts.incomplete = (received_count < expected_length);
    sts.vin_ok     = (received_count >= VIN_MIN_LEN) && header_ok &&
                     (vin_count == CW'(VIN_CHARS));
    sts.out_free   = !out_valid || out_ch.ready;
    sts.emit_last  = (emit_idx == IW'(VIN_CHARS - 1));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_match <= (in_ch.can_id == response_id);
      nbytes   <= (in_ch.byte_count > MAX_BYTES) ? MAX_BYTES : in_ch.byte_count;
      frame    <= in_ch.frame_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response_id     <= RESPONSE_ID_RST;
      capture_active  <= 1'b0;
      expected_length <= '0;
      next_sequence   <= 4'd1;
      received_count  <= '0;
      header_match    <= '0;
      header_ok       <= 1'b0;
      vin_count       <= '0;
      byte_idx        <= '0;
      take_cnt        <= '0;
      emit_idx        <= '0;
    end else begin
      if (cfg_wr_en) begin
        response_id <= cfg_wr_data;
      end
      if (cmd.ff_init) begin
        capture_active  <= 1'b1;
        expected_length <= ff_len;
        next_sequence   <= 4'd1;
        received_count  <= '0;
        header_match    <= '0;
        header_ok       <= 1'b0;
        vin_count       <= '0;
        byte_idx        <= FF_FIRST_BYTE;
        take_cnt        <= (ff_len < 12'(FF_MAX_TAKE)) ? ff_len[2:0] : FF_MAX_TAKE;
      end
      if (cmd.cf_start) begin
        next_sequence <= next_sequence + 4'd1;
        byte_idx      <= CF_FIRST_BYTE;
        take_cnt      <= (remaining < 12'(nm1)) ? remaining[2:0] : nm1;
      end
      if (cmd.feed) begin
        if (received_count < 12'd3) begin
          header_match <= hm_next;
          header_ok    <= (hm_next == 2'd3);
        end else if (collect) begin
          vin_count <= vin_count + CW'(1);
        end
        received_count <= received_count + 12'd1;
        byte_idx       <= byte_idx + 3'd1;
        take_cnt       <= take_cnt - 3'd1;
      end
      if (cmd.cap_clr) begin
        capture_active <= 1'b0;
      end
      if (cmd.emit_clr) begin
        emit_idx <= '0;
      end else if (cmd.emit_inc) begin
        emit_idx <= emit_idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed && collect) begin
      vin_mem[vin_count[IW-1:0]] <= cur_byte;
    end
    rd_data <= vin_mem[emit_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      event_res   <= cmd.evt;
      service_id  <= (cmd.evt == EV_NEGATIVE) ? byte2 : 8'h00;
      reject_code <= (cmd.evt == EV_NEGATIVE) ? byte3 : 8'h00;
      vin_char    <= (cmd.evt == EV_VIN) ? rd_data : 8'h00;
      char_index  <= (cmd.evt == EV_VIN) ? CHAR_IDX_W'(emit_idx) : '0;
      last        <= (cmd.evt == EV_VIN) ? sts.emit_last : 1'b1;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.event_res   = event_res;
  assign out_ch.service_id  = service_id;
  assign out_ch.reject_code = reject_code;
  assign out_ch.vin_char    = vin_char;
  assign out_ch.char_index  = char_index;
  assign out_ch.last        = last;

endmodule

[hdl/isotp_receive_vin_extractor_unit.sv]
// top level of the iso-tp receive reassembler with vin extraction
// flow: each frame is accepted in idle and classified; frames that feed no bytes then load
// their result, while first and consecutive frames first feed their message bytes one at a
// time (up to seven) and then load theirs; a completing vin message then gives its characters
// a new frame is taken only after the result of the last one has been loaded for output;
// each vin character is read from the registered store, then loaded once the output is free
// reset: clears all capture state and sets the response id to 0x60F; the vin store is not cleared
module isotp_receive_vin_extractor_unit #(
  parameter int unsigned VIN_CHARS = 17
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [isotp_pkg::CAN_ID_W-1:0]   cfg_wr_data,
  isotp_in_if.sink                         in_ch,
  isotp_out_if.source                      out_ch
);
  import isotp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  isotp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  isotp_dp #(
    .VIN_CHARS (VIN_CHARS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
